// ===== rtl/core/dnd_pkg.sv =====
// ---------------------------------------------------------------------------
// dnd_pkg
// Shared types and constants for the dns name decompressor core.
// ---------------------------------------------------------------------------
package dnd_pkg;

  // request codes on the input channel
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_DECODE = 1'b1;

  // default sizes
  localparam int MSG_BYTES_DEF = 512;
  localparam int NAME_MAX_DEF  = 255;
  localparam int HOP_MAX_DEF   = 16;

  // label separator
  localparam logic [7:0] DOT_CHAR = 8'h2E;

  // walk position wide enough for any pointer target and store size
  localparam int POS_W = 17;

  // command word handed from front to back
  typedef struct packed {
    logic       is_decode;
    logic [8:0] offset;
    logic [7:0] msg_byte;
  } dnd_cmd_t;

endpackage

// ===== rtl/core/dnd_front.sv =====
// ---------------------------------------------------------------------------
// dnd_front
// Input side: accepts words, drops loads outside the store, forwards the rest.
// ---------------------------------------------------------------------------
module dnd_front #(
  parameter int MSG_BYTES = dnd_pkg::MSG_BYTES_DEF
) (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_req_type,
  input  logic [8:0]        in_offset,
  input  logic [7:0]        in_msg_byte,
  output logic              push,
  output dnd_pkg::dnd_cmd_t push_cmd,
  input  logic              q_full
);
  import dnd_pkg::*;

  logic addr_ok;

  // load address check against store size
  assign addr_ok  = ({8'b0, in_offset} < POS_W'(MSG_BYTES));
  assign in_ready = !q_full;

  // out-of-range loads are consumed with no effect
  always_comb begin
    push_cmd.is_decode = (in_req_type == REQ_DECODE);
    push_cmd.offset    = in_offset;
    push_cmd.msg_byte  = in_msg_byte;
    push = in_valid && in_ready && (push_cmd.is_decode || addr_ok);
  end

endmodule

// ===== rtl/core/dnd_queue.sv =====
// ---------------------------------------------------------------------------
// dnd_queue
// Two-entry command queue between front and back.
// ---------------------------------------------------------------------------
module dnd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dnd_pkg::dnd_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output dnd_pkg::dnd_cmd_t pop_cmd
);
  import dnd_pkg::*;

  dnd_cmd_t   mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_cmd   = mem_r[rp_r];

  // pointer and count update
  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_cmd;
  end

endmodule

// ===== rtl/core/dnd_walker.sv =====
// ---------------------------------------------------------------------------
// dnd_walker
// Back side: owns the message store, runs loads and walks names to results.
// ---------------------------------------------------------------------------
module dnd_walker #(
  parameter int MSG_BYTES = dnd_pkg::MSG_BYTES_DEF,
  parameter int NAME_MAX  = dnd_pkg::NAME_MAX_DEF,
  parameter int HOP_MAX   = dnd_pkg::HOP_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_not_empty,
  input  dnd_pkg::dnd_cmd_t q_cmd,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [63:0]       out_name_chars,
  output logic [3:0]        out_char_count,
  output logic              out_last,
  output logic [9:0]        out_next_offset,
  output logic              out_error
);
  import dnd_pkg::*;

  localparam int AW = $clog2(MSG_BYTES);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_HDR   = 4'd1;
  localparam logic [3:0] S_HDRD  = 4'd2;
  localparam logic [3:0] S_DOT   = 4'd3;
  localparam logic [3:0] S_BODY  = 4'd4;
  localparam logic [3:0] S_BODYD = 4'd5;
  localparam logic [3:0] S_PLO   = 4'd6;
  localparam logic [3:0] S_PLOD  = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [7:0]       store [MSG_BYTES];
  logic [7:0]       rdata_r;
  logic             rd_en, wr_en;
  logic [AW-1:0]    rd_addr;

  logic [3:0]       st_r, st_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt, saved_r, saved_nxt;
  logic             jumped_r, jumped_nxt, err_r, err_nxt;
  logic [7:0]       len_r, len_nxt, rem_r, rem_nxt;
  logic [7:0]       hops_r, hops_nxt;
  logic [5:0]       hi_r, hi_nxt;
  logic [63:0]      buf_r, buf_nxt;
  logic [3:0]       cnt_r, cnt_nxt;

  logic             ov_r, ov_nxt;
  logic [63:0]      oc_r, oc_nxt;
  logic [3:0]       on_r, on_nxt;
  logic             ol_r, ol_nxt, oe_r, oe_nxt;
  logic [9:0]       oo_r, oo_nxt;

  logic             out_free, pos_bad, app_en, app_ok;
  logic [7:0]       app_char;
  logic [9:0]       need;

  assign out_free = !ov_r || out_ready;
  assign pos_bad  = (pos_r >= POS_W'(MSG_BYTES));
  assign rd_addr  = pos_r[AW-1:0];
  assign need     = {2'b0, len_r} + {9'b0, (len_r != 8'd0)} + {2'b0, rdata_r};
  assign app_ok   = (cnt_r != 4'd8) || out_free;

  assign out_valid       = ov_r;
  assign out_name_chars  = oc_r;
  assign out_char_count  = on_r;
  assign out_last        = ol_r;
  assign out_next_offset = oo_r;
  assign out_error       = oe_r;

  // walk sequencer
  always_comb begin
    st_nxt = st_r; pos_nxt = pos_r; saved_nxt = saved_r; jumped_nxt = jumped_r;
    err_nxt = err_r; len_nxt = len_r; rem_nxt = rem_r; hops_nxt = hops_r;
    hi_nxt = hi_r; buf_nxt = buf_r; cnt_nxt = cnt_r;
    ov_nxt = ov_r && !out_ready; oc_nxt = oc_r; on_nxt = on_r; ol_nxt = ol_r;
    oe_nxt = oe_r; oo_nxt = oo_r;
    q_pop = 1'b0; rd_en = 1'b0; wr_en = 1'b0;
    app_en = 1'b0; app_char = DOT_CHAR;
    unique case (st_r)
      S_IDLE: begin
        if (q_not_empty) begin
          q_pop = 1'b1;
          if (!q_cmd.is_decode) begin
            wr_en = 1'b1;
          end else begin
            pos_nxt = {8'b0, q_cmd.offset};
            jumped_nxt = 1'b0; err_nxt = 1'b0; len_nxt = 8'd0; hops_nxt = 8'd0;
            buf_nxt = 64'd0; cnt_nxt = 4'd0;
            st_nxt = S_HDR;
          end
        end
      end
      S_HDR: begin
        if (pos_bad) begin
          err_nxt = 1'b1; st_nxt = S_FIN;
        end else begin
          rd_en = 1'b1; pos_nxt = pos_r + 1'b1; st_nxt = S_HDRD;
        end
      end
      S_HDRD: begin
        if (rdata_r == 8'd0) begin
          st_nxt = S_FIN;
        end else if (rdata_r[7:6] == 2'b11) begin
          hi_nxt = rdata_r[5:0]; st_nxt = S_PLO;
        end else if (rdata_r[7:6] != 2'b00) begin
          err_nxt = 1'b1; st_nxt = S_FIN;
        end else if (need > 10'(NAME_MAX)) begin
          err_nxt = 1'b1; st_nxt = S_FIN;
        end else begin
          rem_nxt = rdata_r;
          st_nxt = (len_r != 8'd0) ? S_DOT : S_BODY;
        end
      end
      S_DOT: begin
        app_en = 1'b1; app_char = DOT_CHAR;
        if (app_ok) st_nxt = S_BODY;
      end
      S_BODY: begin
        if (rem_r == 8'd0) begin
          st_nxt = S_HDR;
        end else if (pos_bad) begin
          err_nxt = 1'b1; st_nxt = S_FIN;
        end else begin
          rd_en = 1'b1; pos_nxt = pos_r + 1'b1; st_nxt = S_BODYD;
        end
      end
      S_BODYD: begin
        app_en = 1'b1; app_char = rdata_r;
        if (app_ok) begin
          rem_nxt = rem_r - 1'b1; st_nxt = S_BODY;
        end
      end
      S_PLO: begin
        if (pos_bad) begin
          err_nxt = 1'b1; st_nxt = S_FIN;
        end else begin
          rd_en = 1'b1; pos_nxt = pos_r + 1'b1; st_nxt = S_PLOD;
        end
      end
      S_PLOD: begin
        if (!jumped_r) begin
          saved_nxt = pos_r; jumped_nxt = 1'b1;
        end
        hops_nxt = hops_r + 1'b1;
        if (hops_nxt > 8'(HOP_MAX)) begin
          err_nxt = 1'b1; st_nxt = S_FIN;
        end else begin
          pos_nxt = {3'b0, hi_r, rdata_r}; st_nxt = S_HDR;
        end
      end
      S_FIN: begin
        if (out_free) begin
          ov_nxt = 1'b1; oc_nxt = buf_r; on_nxt = cnt_r; ol_nxt = 1'b1;
          oe_nxt = err_r;
          oo_nxt = err_r ? 10'd0 : (jumped_r ? saved_r[9:0] : pos_r[9:0]);
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase

    // append one character, flushing a full word first
    if (app_en && app_ok) begin
      len_nxt = len_r + 1'b1;
      if (cnt_r == 4'd8) begin
        ov_nxt = 1'b1; oc_nxt = buf_r; on_nxt = 4'd8; ol_nxt = 1'b0;
        oe_nxt = 1'b0; oo_nxt = 10'd0;
        buf_nxt = {56'd0, app_char}; cnt_nxt = 4'd1;
      end else begin
        buf_nxt[cnt_r[2:0]*8 +: 8] = app_char;
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  // walk and output payload
  always_ff @(posedge clk) begin
    pos_r <= pos_nxt; saved_r <= saved_nxt; jumped_r <= jumped_nxt; err_r <= err_nxt;
    len_r <= len_nxt; rem_r <= rem_nxt; hops_r <= hops_nxt; hi_r <= hi_nxt;
    buf_r <= buf_nxt; cnt_r <= cnt_nxt;
    oc_r <= oc_nxt; on_r <= on_nxt; ol_r <= ol_nxt; oe_r <= oe_nxt; oo_r <= oo_nxt;
  end

  // message store, one write or one read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) store[AW'(q_cmd.offset)] <= q_cmd.msg_byte;
    if (rd_en) rdata_r <= store[rd_addr];
  end

  // a word that is not last is always full
  a_full_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !ol_r) |-> (on_r == 4'd8)) else $error("short middle word");

  // error words carry no offset
  a_err_off: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && oe_r) |-> (oo_r == 10'd0 && ol_r)) else $error("bad error word");

  // packing buffer never overflows
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> (cnt_r <= 4'd8)) else $error("buffer overflow");

  // a new command is only taken from idle
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (st_r == S_IDLE)) else $error("pop while busy");

endmodule

// ===== rtl/core/dns_name_decompressor_core.sv =====
// ---------------------------------------------------------------------------
// dns_name_decompressor_core
// Message store loader and compressed dns name walker.
// ---------------------------------------------------------------------------
// Load words (req_type 0) write one byte each. A decode word leaves the queue,
// then walks the store through its single read port, which has a registered
// read: for each label it reads the length byte, appends a dot before every
// label but the first, then reads and appends each name character; each
// pointer takes two reads and a jump. The walk ends on the terminating zero,
// after which the final word is given. A character or dot that starts a new
// word waits while the previous word is still held in the output register.
// A two-entry queue sits between the input and the walker, so up to two
// further words are queued while a decode is in progress, and the output
// register lets the walker continue while a finished word waits to be taken.
module dns_name_decompressor_core #(
  parameter int MSG_BYTES = dnd_pkg::MSG_BYTES_DEF,
  parameter int NAME_MAX  = dnd_pkg::NAME_MAX_DEF,
  parameter int HOP_MAX   = dnd_pkg::HOP_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [8:0]  in_offset,
  input  logic [7:0]  in_msg_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_name_chars,
  output logic [3:0]  out_char_count,
  output logic        out_last,
  output logic [9:0]  out_next_offset,
  output logic        out_error
);
  import dnd_pkg::*;

  logic     push, q_full, q_pop, q_not_empty;
  dnd_cmd_t push_cmd, pop_cmd;

  // input classification
  dnd_front #(.MSG_BYTES(MSG_BYTES)) u_front (
    .in_valid, .in_ready, .in_req_type, .in_offset, .in_msg_byte,
    .push, .push_cmd, .q_full
  );

  // command queue
  dnd_queue u_queue (
    .clk, .rst_n, .push, .push_cmd, .full(q_full),
    .pop(q_pop), .not_empty(q_not_empty), .pop_cmd
  );

  // store and name walker
  dnd_walker #(.MSG_BYTES(MSG_BYTES), .NAME_MAX(NAME_MAX), .HOP_MAX(HOP_MAX)) u_walker (
    .clk, .rst_n, .q_not_empty, .q_cmd(pop_cmd), .q_pop,
    .out_valid, .out_ready, .out_name_chars, .out_char_count, .out_last,
    .out_next_offset, .out_error
  );

endmodule

// ===== bench/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for dns_name_decompressor_core: loads a message store,
// decodes compressed names and checks every output word against a predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
module testbench;
  import dnd_pkg::*;

  localparam int STORE_BYTES = MSG_BYTES_DEF;
  localparam int HOP_LIMIT   = HOP_MAX_DEF;
  localparam int NAME_LIMIT  = NAME_MAX_DEF;
  localparam int STALL_LIMIT = 6000;

  typedef struct {
    logic       req;
    logic [8:0] off;
    logic [7:0] mbyte;
    bit         drain;
  } req_word_t;

  typedef struct {
    logic [63:0] chars;
    logic [3:0]  cnt;
    logic        last;
    logic [9:0]  nxt;
    logic        err;
  } name_word_t;

  logic        clk, rst_n;
  logic        in_valid, in_ready, in_req_type;
  logic [8:0]  in_offset;
  logic [7:0]  in_msg_byte;
  logic        out_valid, out_ready;
  logic [63:0] out_name_chars;
  logic [3:0]  out_char_count;
  logic        out_last;
  logic [9:0]  out_next_offset;
  logic        out_error;

  dns_name_decompressor_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req_type(in_req_type),
    .in_offset(in_offset), .in_msg_byte(in_msg_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_name_chars(out_name_chars), .out_char_count(out_char_count),
    .out_last(out_last), .out_next_offset(out_next_offset), .out_error(out_error)
  );

  req_word_t  pending_words[$];
  name_word_t expected_names[$];
  logic [7:0] shadow_store[STORE_BYTES];
  int mismatches = 0, loads_seen = 0, decodes_seen = 0, words_seen = 0, errors_seen = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  bit calm = 0;
  bit stim_done = 0;

  // clock
  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // predictor: apply one accepted word to the shadow store or walk the name
  task automatic predict_word(logic req, logic [8:0] off, logic [7:0] mbyte);
    logic [7:0] name_buf[256];
    logic [7:0] b, lo;
    int pos, len, saved, hops, need, nres, cnt;
    bit jumped, err;
    name_word_t w;
    if (req == REQ_LOAD) begin
      shadow_store[off] = mbyte;
      return;
    end
    pos = off; len = 0; saved = 0; hops = 0; jumped = 0; err = 0;
    forever begin
      if (pos >= STORE_BYTES) begin err = 1; break; end
      b = shadow_store[pos]; pos++;
      if (b == 8'h00) break;
      if (b[7:6] == 2'b11) begin
        if (pos >= STORE_BYTES) begin err = 1; break; end
        lo = shadow_store[pos]; pos++;
        if (!jumped) begin saved = pos; jumped = 1; end
        hops++;
        if (hops > HOP_LIMIT) begin err = 1; break; end
        pos = {b[5:0], lo};
      end else if (b[7:6] != 2'b00) begin
        err = 1; break;
      end else begin
        need = len + (len > 0 ? 1 : 0) + b;
        if (need > NAME_LIMIT) begin err = 1; break; end
        if (len > 0) begin name_buf[len] = DOT_CHAR; len++; end
        for (int i = 0; i < b; i++) begin
          if (pos >= STORE_BYTES) begin err = 1; break; end
          name_buf[len] = shadow_store[pos]; pos++; len++;
        end
        if (err) break;
      end
    end
    nres = (len == 0) ? 1 : (len + 7) / 8;
    for (int k = 0; k < nres; k++) begin
      cnt = (len > k * 8) ? len - k * 8 : 0;
      if (cnt > 8) cnt = 8;
      w.chars = '0;
      for (int j = 0; j < cnt; j++) w.chars[8*j +: 8] = name_buf[k*8 + j];
      w.cnt  = 4'(cnt);
      w.last = (k + 1 == nres);
      w.nxt  = (w.last && !err) ? 10'(jumped ? saved : pos) : 10'd0;
      w.err  = w.last && err;
      expected_names = {expected_names, w};
    end
  endtask

  // driver
  always @(posedge clk) begin
    req_word_t nxt_word;
    logic nv;
    if (!rst_n) begin
      in_valid <= 1'b0; in_req_type <= REQ_LOAD; in_offset <= '0; in_msg_byte <= '0;
    end else begin
      nv = in_valid;
      if (in_valid && in_ready) begin
        predict_word(in_req_type, in_offset, in_msg_byte);
        if (in_req_type == REQ_LOAD) loads_seen++; else decodes_seen++;
        nv = 1'b0;
        if (!calm && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 11);
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_words.size() > 0 &&
                     !(pending_words[0].drain && expected_names.size() > 0)) begin
          nxt_word = pending_words.pop_front();
          in_req_type <= nxt_word.req;
          in_offset   <= nxt_word.off;
          in_msg_byte <= nxt_word.mbyte;
          nv = 1'b1;
        end
      end
      in_valid <= nv;
      if (pending_words.size() < 40 && stim_done) calm = 1;
    end
  end

  // monitor and receiver stalls
  int stall_left = 0;
  bit long_hold_done = 0;
  always @(posedge clk) begin
    name_word_t w;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        words_seen++;
        if (expected_names.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected output word: chars=%h", out_name_chars);
        end else begin
          w = expected_names.pop_front();
          if (out_last) begin
            if (out_error) errors_seen++;
          end
          if (out_name_chars !== w.chars || out_char_count !== w.cnt ||
              out_last !== w.last || out_next_offset !== w.nxt || out_error !== w.err) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("word mismatch: exp chars=%h cnt=%0d last=%0d next=%0d err=%0d",
                       w.chars, w.cnt, w.last, w.nxt, w.err);
              $display("               got chars=%h cnt=%0d last=%0d next=%0d err=%0d",
                       out_name_chars, out_char_count, out_last, out_next_offset,
                       out_error);
            end
          end
        end
        // one long hold-off so the input side backs up
        if (!long_hold_done && words_seen == 20) begin
          long_hold_done = 1;
          stall_left = 300;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
      // watchdog
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", idle_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // stimulus helpers
  function automatic void add_load(int a, logic [7:0] v);
    req_word_t w;
    w.req = REQ_LOAD; w.off = a[8:0]; w.mbyte = v; w.drain = 0;
    pending_words = {pending_words, w};
  endfunction

  function automatic void add_decode(int a, bit drain = 0);
    req_word_t w;
    w.req = REQ_DECODE; w.off = a[8:0]; w.mbyte = 8'($urandom); w.drain = drain;
    pending_words = {pending_words, w};
  endfunction

  // write one label of given length with random characters, return next address
  function automatic int put_label(int a, int n);
    add_load(a, 8'(n));
    for (int i = 1; i <= n; i++) add_load(a + i, 8'($urandom));
    return a + n + 1;
  endfunction

  int starts[$];

  initial begin
    int a, base, nlab, tgt, next_free;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // label that points back to itself: 255 characters, then the next copy is too long
    a = put_label(330, 63);
    add_load(a, 8'hC1); add_load(a + 1, 8'h4A);
    add_decode(330);
    // pointer to itself runs into the hop limit
    add_load(400, 8'hC1); add_load(401, 8'h90); add_decode(400);
    // reserved length types
    add_load(410, 8'h40); add_load(411, 8'h80); add_decode(410); add_decode(411);
    // root name
    add_load(420, 8'h00); add_decode(420);
    // pointer targets outside the store
    add_load(430, 8'hC2); add_load(431, 8'h00); add_decode(430);
    add_load(440, 8'hFF); add_load(441, 8'hFF); add_decode(440);
    // label then pointer to the root
    add_load(450, 8'h01); add_load(451, 8'h61); add_load(452, 8'hC1); add_load(453, 8'hA4);
    add_decode(450);
    // label body and pointer low byte running off the end
    add_load(509, 8'h05); add_load(510, 8'($urandom)); add_load(511, 8'hC0);
    add_decode(509); add_decode(511, 1);

    // random names laid out back to back, some compressed against earlier names
    next_free = 0;
    for (int it = 0; it < 10 && next_free < 250; it++) begin
      base = next_free;
      nlab = $urandom_range(1, 4);
      a = base;
      for (int l = 0; l < nlab && a < 280; l++)
        a = put_label(a, ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20)
                                                     : $urandom_range(1, 8));
      case ($urandom_range(0, 3))
        0, 1: begin
          add_load(a, 8'h00);
          next_free = a + 1;
        end
        2: begin
          tgt = (starts.size() > 0) ? starts[$urandom_range(0, starts.size() - 1)] : 420;
          add_load(a, {2'b11, 6'(tgt >> 8)}); add_load(a + 1, 8'(tgt));
          next_free = a + 2;
        end
        default: begin
          tgt = $urandom_range(STORE_BYTES, 16383);
          add_load(a, {2'b11, 6'(tgt >> 8)}); add_load(a + 1, 8'(tgt));
          next_free = a + 2;
        end
      endcase
      starts = {starts, base};
      add_decode(base, it == 4);
      if ($urandom_range(0, 2) == 0) add_decode(starts[$urandom_range(0, starts.size() - 1)]);
    end
    stim_done = 1;

    wait (pending_words.size() == 0 && !in_valid);
    wait (expected_names.size() == 0);
    repeat (200) @(posedge clk);

    $display("covered %0d loads and %0d decodes, %0d output words checked, %0d failed decodes",
             loads_seen, decodes_seen, words_seen, errors_seen);
    if (mismatches == 0 && expected_names.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d words outstanding", mismatches, expected_names.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
